>>> rtl/mbs_pkg.sv
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared types, constants and sine table helpers for the blade shading block.
// ----------------------------------------------------------------------------
package mbs_pkg;

   // default parameter values
   localparam int PHASE_BITS_DEF   = 16;
   localparam int SINE_ENTRIES_DEF = 256;

   // front to back queue
   localparam int QUEUE_DEPTH = 2;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   // reset values of the configuration registers
   localparam logic [8:0]  BASE_HUE_RST    = 9'd0;
   localparam logic [11:0] IDLE_FREQ_RST   = 12'd256;
   localparam logic [8:0]  PULSE_DEPTH_RST = 9'd64;
   localparam logic [8:0]  BLEED_MAX_RST   = 9'd128;
   localparam logic [8:0]  FLICKER_RST     = 9'd256;

   // shared multiplier
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 21;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // phase step: round(delta * freq * 2^PHASE_BITS / 256000)
   localparam int STEP_PROD_W = 29;
   localparam int STEP_ROUND  = 128000;
   localparam int DIV_SHIFT   = 11;
   localparam int DIV_CONST   = 125;

   // hue, excitation and brightness constants
   localparam int FULL_TURN     = 360;
   localparam int HALF_TURN     = 180;
   localparam int EXCITE_ENERGY = 128;
   localparam int ENERGY_CAP    = 1024;
   localparam int BRIGHT_FLOOR  = 204;
   localparam int SINE_ONE      = 16384;
   localparam int FREQ_LIFT     = 16448;
   localparam int FREQ_OFFSET   = 128;

   // two pi in Q30
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

   // configuration register index
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_HUE    = 3'd0,
      CSR_IDLE_FREQ   = 3'd1,
      CSR_PULSE_DEPTH = 3'd2,
      CSR_BLEED_MAX   = 3'd3,
      CSR_FLICKER     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [15:0]        kinetic_energy;
      logic signed [15:0] tilt;
      logic [11:0]        overload;
      logic               burst;
      logic [31:0]        time_ms;
      logic [31:0]        random_word;
   } req_type;

   typedef struct packed {
      logic [8:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
      logic       flash_request;
      logic [8:0] flash_hue;
   } rsp_type;

   typedef struct packed {
      logic [8:0]  base_hue;
      logic [11:0] idle_base_freq;
      logic [8:0]  pulse_depth;
      logic [8:0]  thermal_bleed_max;
      logic [8:0]  flicker_intensity;
   } cfg_type;

   // classified sample handed from front to back
   typedef struct packed {
      logic signed [15:0] tilt;
      logic [15:0]        delta;
      logic               excited;
      logic [11:0]        overload;
      logic [10:0]        energy_cap;
      logic [31:0]        noise_mag;
      logic               burst;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_TILT_MUL,
      ST_TILT_SINE,
      ST_STEP_MUL,
      ST_DIV_LOAD,
      ST_DIV,
      ST_PHASE,
      ST_LOSS_MUL,
      ST_EF_MUL,
      ST_FLICK_MUL,
      ST_FLICK_BRIGHT,
      ST_PHASE_MUL,
      ST_PHASE_SINE,
      ST_PULSE_MUL,
      ST_PULSE_BRIGHT,
      ST_DONE
   } back_state_type;

   // sin(x) for x in [0, pi/2], Q30 in and out, odd taylor terms
   function automatic logic [63:0] sin_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
      return sum;
   endfunction

   // one table entry in Q1.14 from a folded angle
   function automatic logic signed [15:0] sine_value(input logic [63:0] angle,
                                                     input logic negative);
      logic [63:0] v;
      v = (sin_q30(angle) + 64'd32768) >> 16;
      if (v > 64'd16384) begin
         v = 64'd16384;
      end
      return negative ? -$signed(v[15:0]) : $signed(v[15:0]);
   endfunction

endpackage

>>> rtl/mbs_front.sv
// ----------------------------------------------------------------------------
// mbs_front
// Accepts motion samples, measures elapsed time and classifies the sample.
// ----------------------------------------------------------------------------
module mbs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  mbs_pkg::req_type  req,
   output mbs_pkg::work_type work
);

   logic [31:0] last_time_ff;
   logic [31:0] last_time_in;
   logic [31:0] since;
   logic [31:0] diff;

   // elapsed time, zero on the first sample, saturated to 16 bits
   always_comb begin
      since = (last_time_ff == 32'd0) ? req.time_ms : last_time_ff;
      diff  = req.time_ms - since;
   end

   always_comb begin
      last_time_in = accept ? req.time_ms : last_time_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= 32'd0;
      end else begin
         last_time_ff <= last_time_in;
      end
   end

   // classification and noise magnitude |2r - (2^32 - 1)|
   always_comb begin
      work.tilt     = req.tilt;
      work.delta    = (|diff[31:16]) ? 16'hFFFF : diff[15:0];
      work.overload = req.overload;
      work.burst    = req.burst;
      work.excited  = (req.kinetic_energy >= 16'(mbs_pkg::EXCITE_ENERGY))
                      || (req.overload != 12'd0);
      work.energy_cap = (req.kinetic_energy > 16'(mbs_pkg::ENERGY_CAP))
                        ? 11'(mbs_pkg::ENERGY_CAP) : req.kinetic_energy[10:0];
      work.noise_mag = req.random_word[31] ? {req.random_word[30:0], 1'b1}
                                           : ~{req.random_word[30:0], 1'b0};
   end

endmodule

>>> rtl/mbs_queue.sv
// ----------------------------------------------------------------------------
// mbs_queue
// Short queue of classified samples between the front and the back.
// ----------------------------------------------------------------------------
module mbs_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mbs_pkg::work_type         wdata,
   input  logic                      pop,
   output mbs_pkg::work_type         rdata,
   output mbs_pkg::queue_status_type status
);

   localparam int DEPTH = mbs_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mbs_pkg::work_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata        = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

>>> rtl/mbs_back.sv
// ----------------------------------------------------------------------------
// mbs_back
// Sequencer with a shared multiplier and a radix-16 divider by 125 that
// advances the breathing phase and computes saturation and brightness.
// ----------------------------------------------------------------------------
module mbs_back #(
   parameter int PHASE_BITS   = mbs_pkg::PHASE_BITS_DEF,
   parameter int SINE_ENTRIES = mbs_pkg::SINE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  mbs_pkg::cfg_type  cfg,
   input  mbs_pkg::work_type work,
   input  logic              q_empty,
   output logic              q_pop,
   input  logic              pop,
   output logic              rsp_valid,
   output mbs_pkg::rsp_type  rsp
);

   localparam int IDX_W     = $clog2(SINE_ENTRIES);
   localparam int HALF      = SINE_ENTRIES / 2;
   localparam int QUARTER   = SINE_ENTRIES / 4;
   localparam int PROD_W    = mbs_pkg::PROD_W;
   localparam int STEP_X_W  = mbs_pkg::STEP_PROD_W + PHASE_BITS + 1;
   localparam int QUO_W     = STEP_X_W - mbs_pkg::DIV_SHIFT;
   localparam int DIV_STEPS = (QUO_W + 3) / 4;
   localparam int DIV_W     = 4 * DIV_STEPS;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   // sine table over one full turn
   logic signed [15:0] sine_rom [SINE_ENTRIES];

   for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_sine
      localparam int J0 = g % HALF;
      localparam int J  = (J0 > QUARTER) ? (HALF - J0) : J0;
      localparam logic [63:0] ANGLE = (64'(J) * mbs_pkg::TWO_PI_Q30) / SINE_ENTRIES;
      localparam logic signed [15:0] VALUE = mbs_pkg::sine_value(ANGLE, g >= HALF);
      assign sine_rom[g] = VALUE;
   end

   mbs_pkg::back_state_type state_ff, state_in;
   mbs_pkg::work_type       work_ff, work_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [12:0]             freq_ff, freq_in;
   logic signed [15:0]      sine_ff, sine_in;
   logic [DIV_W-1:0]        div_ff, div_in;
   logic [6:0]              rem_ff, rem_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [PHASE_BITS-1:0]   phase_ff, phase_in;
   logic [7:0]              sat_ff, sat_in;
   logic [7:0]              bright_ff, bright_in;
   mbs_pkg::rsp_type        rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [mbs_pkg::MUL_A_W-1:0] mul_a;
   logic [mbs_pkg::MUL_B_W-1:0] mul_b;
   logic                        load_rsp;
   logic                        use_tilt;

   // sine table read with rounding of the turn fraction
   logic [PROD_W-1:0] round_sum;
   logic [IDX_W:0]    idx_raw;
   logic [IDX_W-1:0]  sine_idx;
   logic signed [15:0] sine_rd;

   always_comb begin
      if (use_tilt) begin
         round_sum = prod_ff + (PROD_W'(1) << 15);
         idx_raw   = round_sum[16 +: IDX_W + 1];
      end else begin
         round_sum = prod_ff + (PROD_W'(1) << (PHASE_BITS - 1));
         idx_raw   = round_sum[PHASE_BITS +: IDX_W + 1];
      end
      sine_idx = (idx_raw >= (IDX_W + 1)'(SINE_ENTRIES)) ? '0 : idx_raw[IDX_W-1:0];
      sine_rd  = sine_rom[sine_idx];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mbs_pkg::ST_IDLE:         if (!q_empty) state_in = mbs_pkg::ST_TILT_MUL;
         mbs_pkg::ST_TILT_MUL:     state_in = mbs_pkg::ST_TILT_SINE;
         mbs_pkg::ST_TILT_SINE:    state_in = mbs_pkg::ST_STEP_MUL;
         mbs_pkg::ST_STEP_MUL:     state_in = mbs_pkg::ST_DIV_LOAD;
         mbs_pkg::ST_DIV_LOAD:     state_in = mbs_pkg::ST_DIV;
         mbs_pkg::ST_DIV:          if (cnt_ff == CNT_W'(1)) state_in = mbs_pkg::ST_PHASE;
         mbs_pkg::ST_PHASE:        state_in = work_ff.excited ? mbs_pkg::ST_LOSS_MUL
                                                              : mbs_pkg::ST_PHASE_MUL;
         mbs_pkg::ST_LOSS_MUL:     state_in = mbs_pkg::ST_EF_MUL;
         mbs_pkg::ST_EF_MUL:       state_in = mbs_pkg::ST_FLICK_MUL;
         mbs_pkg::ST_FLICK_MUL:    state_in = mbs_pkg::ST_FLICK_BRIGHT;
         mbs_pkg::ST_FLICK_BRIGHT: state_in = mbs_pkg::ST_DONE;
         mbs_pkg::ST_PHASE_MUL:    state_in = mbs_pkg::ST_PHASE_SINE;
         mbs_pkg::ST_PHASE_SINE:   state_in = mbs_pkg::ST_PULSE_MUL;
         mbs_pkg::ST_PULSE_MUL:    state_in = mbs_pkg::ST_PULSE_BRIGHT;
         mbs_pkg::ST_PULSE_BRIGHT: state_in = mbs_pkg::ST_DONE;
         mbs_pkg::ST_DONE:         if (load_rsp) state_in = mbs_pkg::ST_IDLE;
         default:                  state_in = mbs_pkg::ST_IDLE;
      endcase
   end

   // control outputs and multiplier operand selection
   logic signed [16:0] pulse_gap;

   always_comb begin
      pulse_gap = 17'sd16384 - 17'(sine_ff);
      mul_a     = '0;
      mul_b     = '0;
      q_pop     = 1'b0;
      load_rsp  = 1'b0;
      use_tilt  = 1'b0;
      case (state_ff)
         mbs_pkg::ST_IDLE: begin
            q_pop = !q_empty;
         end
         mbs_pkg::ST_TILT_MUL: begin
            mul_a = 32'(unsigned'(work_ff.tilt));
            mul_b = 21'(SINE_ENTRIES);
         end
         mbs_pkg::ST_TILT_SINE: begin
            use_tilt = 1'b1;
         end
         mbs_pkg::ST_STEP_MUL: begin
            mul_a = 32'(work_ff.delta);
            mul_b = 21'(freq_ff);
         end
         mbs_pkg::ST_PHASE_MUL: begin
            mul_a = 32'(phase_ff);
            mul_b = 21'(SINE_ENTRIES);
         end
         mbs_pkg::ST_LOSS_MUL: begin
            mul_a = 32'(work_ff.overload);
            mul_b = 21'(cfg.thermal_bleed_max);
         end
         mbs_pkg::ST_EF_MUL: begin
            mul_a = 32'(work_ff.energy_cap);
            mul_b = 21'(cfg.flicker_intensity);
         end
         mbs_pkg::ST_FLICK_MUL: begin
            mul_a = work_ff.noise_mag;
            mul_b = prod_ff[20:0];
         end
         mbs_pkg::ST_PULSE_MUL: begin
            mul_a = 32'(cfg.pulse_depth);
            mul_b = 21'(unsigned'(pulse_gap));
         end
         mbs_pkg::ST_DONE: begin
            load_rsp = !rsp_valid_ff || pop;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // datapath
   logic [17:0]         freq_lift;
   logic [12:0]         freq_sum;
   logic [STEP_X_W-1:0] step_x;
   logic [7:0]          div_r;
   logic [3:0]          div_q;
   logic [20:0]         loss;
   logic [20:0]         sat_s;
   logic [28:0]         sat_x255;
   logic [17:0]         flick_raw;
   logic [16:0]         flick_dip;
   logic [17:0]         flick_v;
   logic [25:0]         flick_x255;
   logic [24:0]         pulse_raw;
   logic [23:0]         pulse_dip;
   logic [23:0]         pulse_v;
   logic [31:0]         pulse_x255;
   logic [8:0]          hue;

   always_comb begin
      work_in      = work_ff;
      prod_in      = mul_a * mul_b;
      freq_in      = freq_ff;
      sine_in      = sine_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      sat_in       = sat_ff;
      bright_in    = bright_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      // frequency bent by the tilt sine, floored at zero
      freq_lift = 18'(unsigned'(18'(sine_rd) + 18'sd16448));
      freq_sum  = 13'(cfg.idle_base_freq) + 13'(freq_lift[15:7]);

      // phase step dividend before the divide by 125
      step_x = {1'b0, prod_ff[mbs_pkg::STEP_PROD_W-1:0], PHASE_BITS'(0)}
               + STEP_X_W'(mbs_pkg::STEP_ROUND);

      // one radix-16 digit of the divide by 125
      div_r = {1'b0, rem_ff};
      div_q = '0;
      for (int i = 3; i >= 0; i--) begin
         div_r = {div_r[6:0], div_ff[DIV_W - 4 + i]};
         if (div_r >= 8'(mbs_pkg::DIV_CONST)) begin
            div_r    = div_r - 8'(mbs_pkg::DIV_CONST);
            div_q[i] = 1'b1;
         end
      end

      // saturation from overload
      loss     = prod_ff[20:0];
      sat_s    = loss[20] ? 21'd0 : 21'd1048576 - loss;
      sat_x255 = {sat_s, 8'd0} - 29'(sat_s);

      // flicker brightness
      flick_raw  = prod_ff[51:34];
      flick_dip  = (flick_raw > 18'd65536) ? 17'd65536 : flick_raw[16:0];
      flick_v    = 18'd65536 - 18'(flick_dip);
      flick_x255 = {flick_v, 8'd0} - 26'(flick_v);

      // idle pulse brightness
      pulse_raw  = prod_ff[24:0];
      pulse_dip  = (pulse_raw > 25'd8388608) ? 24'd8388608 : pulse_raw[23:0];
      pulse_v    = 24'd8388608 - pulse_dip;
      pulse_x255 = {pulse_v, 8'd0} - 32'(pulse_v);

      // hue and its complement
      hue = (cfg.base_hue >= 9'(mbs_pkg::FULL_TURN))
            ? cfg.base_hue - 9'(mbs_pkg::FULL_TURN) : cfg.base_hue;

      if (q_pop) begin
         work_in = work;
      end
      if (pop) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         mbs_pkg::ST_TILT_SINE: begin
            freq_in = (freq_sum < 13'(mbs_pkg::FREQ_OFFSET)) ? 13'd0
                      : freq_sum - 13'(mbs_pkg::FREQ_OFFSET);
         end
         mbs_pkg::ST_DIV_LOAD: begin
            div_in = DIV_W'(step_x[STEP_X_W-1:mbs_pkg::DIV_SHIFT]);
            rem_in = '0;
            cnt_in = CNT_W'(DIV_STEPS);
         end
         mbs_pkg::ST_DIV: begin
            div_in = {div_ff[DIV_W-5:0], div_q};
            rem_in = div_r[6:0];
            cnt_in = cnt_ff - 1'b1;
         end
         mbs_pkg::ST_PHASE: begin
            phase_in = phase_ff + div_ff[PHASE_BITS-1:0];
         end
         mbs_pkg::ST_EF_MUL: begin
            sat_in = sat_x255[27:20];
         end
         mbs_pkg::ST_FLICK_BRIGHT: begin
            bright_in = (flick_x255[23:16] < 8'(mbs_pkg::BRIGHT_FLOOR))
                        ? 8'(mbs_pkg::BRIGHT_FLOOR) : flick_x255[23:16];
         end
         mbs_pkg::ST_PHASE_SINE: begin
            sine_in = sine_rd;
         end
         mbs_pkg::ST_PULSE_BRIGHT: begin
            sat_in    = 8'd255;
            bright_in = pulse_x255[30:23];
         end
         mbs_pkg::ST_DONE: begin
            if (load_rsp) begin
               rsp_in.hue           = hue;
               rsp_in.saturation    = sat_ff;
               rsp_in.brightness    = bright_ff;
               rsp_in.flash_request = work_ff.burst;
               rsp_in.flash_hue     = (hue >= 9'(mbs_pkg::HALF_TURN))
                                      ? hue - 9'(mbs_pkg::HALF_TURN)
                                      : hue + 9'(mbs_pkg::HALF_TURN);
               rsp_valid_in         = 1'b1;
            end
         end
         default: begin
            freq_in = freq_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbs_pkg::ST_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      prod_ff   <= prod_in;
      freq_ff   <= freq_in;
      sine_ff   <= sine_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      sat_ff    <= sat_in;
      bright_ff <= bright_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> rtl/motion_driven_blade_shading.sv
// ----------------------------------------------------------------------------
// motion_driven_blade_shading
// Motion sample in, hue / saturation / brightness out, with breathing phase.
// ----------------------------------------------------------------------------
// Each accepted sample gives exactly one result. The front measures elapsed
// time and classifies the sample in the cycle it is accepted and parks it in a
// two-entry queue; the back works on one sample at a time. Its serial divider
// forms DIV_STEPS = ceil((PHASE_BITS + 19) / 4) radix-16 digits of the divide
// by 125 in the phase step, and its steps share a single multiplier.
// Samples keep being accepted while the queue has room and a finished result
// waits on the result ports.
module motion_driven_blade_shading #(
   parameter int PHASE_BITS   = mbs_pkg::PHASE_BITS_DEF,
   parameter int SINE_ENTRIES = mbs_pkg::SINE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample channel
   input  logic                              push,
   output logic                              full,
   input  mbs_pkg::req_type                  req_data,
   // result channel
   output logic                              empty,
   input  logic                              pop,
   output mbs_pkg::rsp_type                  rsp_data,
   // register write channel
   input  logic                              valid,
   output logic                              ready,
   input  logic [mbs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mbs_pkg::CSR_DATA_W-1:0]    csr_data
);

   mbs_pkg::cfg_type          cfg_ff, cfg_in;
   mbs_pkg::work_type         front_work;
   mbs_pkg::work_type         q_rdata;
   mbs_pkg::queue_status_type q_status;
   logic                      accept;
   logic                      q_pop;
   logic                      rsp_valid;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (valid) begin
         case (mbs_pkg::csr_index_type'(csr_index))
            mbs_pkg::CSR_BASE_HUE:    cfg_in.base_hue          = csr_data[8:0];
            mbs_pkg::CSR_IDLE_FREQ:   cfg_in.idle_base_freq    = csr_data;
            mbs_pkg::CSR_PULSE_DEPTH: cfg_in.pulse_depth       = csr_data[8:0];
            mbs_pkg::CSR_BLEED_MAX:   cfg_in.thermal_bleed_max = csr_data[8:0];
            mbs_pkg::CSR_FLICKER:     cfg_in.flicker_intensity = csr_data[8:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_hue          <= mbs_pkg::BASE_HUE_RST;
         cfg_ff.idle_base_freq    <= mbs_pkg::IDLE_FREQ_RST;
         cfg_ff.pulse_depth       <= mbs_pkg::PULSE_DEPTH_RST;
         cfg_ff.thermal_bleed_max <= mbs_pkg::BLEED_MAX_RST;
         cfg_ff.flicker_intensity <= mbs_pkg::FLICKER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign ready  = 1'b1;
   assign accept = push && !q_status.full;
   assign full   = q_status.full;
   assign empty  = !rsp_valid;

   // sample intake and classification
   mbs_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .work   (front_work)
   );

   // decoupling queue
   mbs_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (accept),
      .wdata  (front_work),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   // shading sequencer
   mbs_back #(
      .PHASE_BITS   (PHASE_BITS),
      .SINE_ENTRIES (SINE_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .work      (q_rdata),
      .q_empty   (q_status.empty),
      .q_pop     (q_pop),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

   // back never takes from an empty queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_status.empty)
      else $error("back popped an empty queue");

   // queue cannot be full and empty at once
   assert property (@(posedge clock) disable iff (reset)
                    !(q_status.full && q_status.empty))
      else $error("queue status inconsistent");

   // a pending result always carries hues within one turn
   assert property (@(posedge clock) disable iff (reset)
                    !empty |-> (rsp_data.hue < 9'd360) && (rsp_data.flash_hue < 9'd360))
      else $error("result hue out of range");

endmodule

>>> tb/motion_driven_blade_shading_checker.sv
// ----------------------------------------------------------------------------
// motion_driven_blade_shading_checker
// Watches the sample, result and register channels of the blade shading block,
// keeps its own copy of the breathing phase, time base and registers, predicts
// each result at sample acceptance and compares results field by field.
// ----------------------------------------------------------------------------
module motion_driven_blade_shading_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic                            full,
   input  mbs_pkg::req_type                req_data,
   input  logic                            empty,
   input  logic                            pop,
   input  mbs_pkg::rsp_type                rsp_data,
   input  logic                            valid,
   input  logic                            ready,
   input  logic [mbs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mbs_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                              fail_count,
   output int                              pending,
   output int                              checked
);

   // predictor state
   logic signed [15:0] sine_lut [256];
   logic [15:0]        phase_acc;
   logic [31:0]        prev_ms;
   mbs_pkg::cfg_type   regs;
   mbs_pkg::rsp_type   shade_queue [$];

   // taylor series sine, Q30 in and out, x within a quarter turn
   function automatic longint unsigned quarter_sine(input longint unsigned x);
      longint unsigned x2, term, sum;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      return sum;
   endfunction

   initial begin
      longint unsigned j, v;
      for (int i = 0; i < 256; i++) begin
         j = i % 128;
         if (j > 64) j = 128 - j;
         v = (quarter_sine(j * 64'd6746518852 / 256) + 64'd32768) >> 16;
         if (v > 16384) v = 16384;
         sine_lut[i] = (i >= 128) ? -$signed(16'(v)) : $signed(16'(v));
      end
   end

   // table sine of a 16 bit turn fraction, rounded to nearest entry
   function automatic int turn_sine(input logic [15:0] turn);
      longint unsigned idx;
      idx = ((longint'(turn) * 256) + 32768) >> 16;
      return sine_lut[idx % 256];
   endfunction

   // expected shading for one sample, advances the phase and time base
   function automatic mbs_pkg::rsp_type shade_sample(input mbs_pkg::req_type s);
      mbs_pkg::rsp_type r;
      longint unsigned  dt, step, sat, bright, loss, s20, m, e, dip;
      longint           freq, d;
      int               hue;
      if (prev_ms == 0) prev_ms = s.time_ms;
      dt = 32'(s.time_ms - prev_ms);
      if (dt > 65535) dt = 65535;
      prev_ms = s.time_ms;
      freq = longint'(regs.idle_base_freq)
           + ((turn_sine(s.tilt) + 16384 + 64) >>> 7) - 128;
      if (freq < 0) freq = 0;
      step = ((dt * longint'(freq) << 16) + 128000) / 256000;
      phase_acc = phase_acc + 16'(step);
      if (s.kinetic_energy >= mbs_pkg::EXCITE_ENERGY || s.overload != 0) begin
         loss = longint'(s.overload) * regs.thermal_bleed_max;
         s20  = (loss >= (64'd1 << 20)) ? 0 : (64'd1 << 20) - loss;
         d    = 2 * longint'(s.random_word) - longint'(32'hFFFF_FFFF);
         m    = (d < 0) ? -d : d;
         e    = (s.kinetic_energy > mbs_pkg::ENERGY_CAP) ? mbs_pkg::ENERGY_CAP
                                                         : s.kinetic_energy;
         dip  = (m * e * regs.flicker_intensity) >> 34;
         if (dip > 65536) dip = 65536;
         sat    = (s20 * 255) >> 20;
         bright = ((65536 - dip) * 255) >> 16;
         if (bright < mbs_pkg::BRIGHT_FLOOR) bright = mbs_pkg::BRIGHT_FLOOR;
      end else begin
         dip = longint'(regs.pulse_depth) * longint'(16384 - turn_sine(phase_acc));
         if (dip > (64'd1 << 23)) dip = 64'd1 << 23;
         sat    = 255;
         bright = (((64'd1 << 23) - dip) * 255) >> 23;
      end
      hue = regs.base_hue % mbs_pkg::FULL_TURN;
      r.hue           = 9'(hue);
      r.saturation    = 8'(sat);
      r.brightness    = 8'(bright);
      r.flash_request = s.burst;
      r.flash_hue     = 9'((hue + mbs_pkg::HALF_TURN) % mbs_pkg::FULL_TURN);
      return r;
   endfunction

   // register writes, sample predictions and result checks
   always @(posedge clock) begin
      mbs_pkg::rsp_type want;
      if (reset) begin
         phase_acc              = '0;
         prev_ms                = '0;
         regs.base_hue          = mbs_pkg::BASE_HUE_RST;
         regs.idle_base_freq    = mbs_pkg::IDLE_FREQ_RST;
         regs.pulse_depth       = mbs_pkg::PULSE_DEPTH_RST;
         regs.thermal_bleed_max = mbs_pkg::BLEED_MAX_RST;
         regs.flicker_intensity = mbs_pkg::FLICKER_RST;
         shade_queue.delete();
         fail_count <= 0;
         checked    <= 0;
         pending    <= 0;
      end else begin
         if (valid && ready) begin
            case (mbs_pkg::csr_index_type'(csr_index))
               mbs_pkg::CSR_BASE_HUE:    regs.base_hue          = csr_data[8:0];
               mbs_pkg::CSR_IDLE_FREQ:   regs.idle_base_freq    = csr_data[11:0];
               mbs_pkg::CSR_PULSE_DEPTH: regs.pulse_depth       = csr_data[8:0];
               mbs_pkg::CSR_BLEED_MAX:   regs.thermal_bleed_max = csr_data[8:0];
               mbs_pkg::CSR_FLICKER:     regs.flicker_intensity = csr_data[8:0];
               default: ;
            endcase
         end
         if (push && !full) shade_queue.push_back(shade_sample(req_data));
         if (pop && !empty) begin
            checked <= checked + 1;
            if (shade_queue.size() == 0) begin
               $error("result transaction with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               want = shade_queue.pop_front();
               if (want !== rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (want.hue !== rsp_data.hue)
                     $error("hue exp %0d got %0d", want.hue, rsp_data.hue);
                  if (want.saturation !== rsp_data.saturation)
                     $error("saturation exp %0d got %0d", want.saturation,
                            rsp_data.saturation);
                  if (want.brightness !== rsp_data.brightness)
                     $error("brightness exp %0d got %0d", want.brightness,
                            rsp_data.brightness);
                  if (want.flash_request !== rsp_data.flash_request)
                     $error("flash_request exp %0d got %0d", want.flash_request,
                            rsp_data.flash_request);
                  if (want.flash_hue !== rsp_data.flash_hue)
                     $error("flash_hue exp %0d got %0d", want.flash_hue,
                            rsp_data.flash_hue);
               end
            end
         end
         pending <= shade_queue.size();
      end
   end

endmodule

>>> tb/motion_driven_blade_shading_tb.sv
// ----------------------------------------------------------------------------
// motion_driven_blade_shading_tb
// Drives motion samples and register settings into the blade shading block
// under random back pressure; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module motion_driven_blade_shading_tb;

   logic                            clock;
   logic                            reset;
   logic                            push;
   logic                            full;
   mbs_pkg::req_type                req_data;
   logic                            empty;
   logic                            pop;
   mbs_pkg::rsp_type                rsp_data;
   logic                            valid;
   logic                            ready;
   logic [mbs_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [mbs_pkg::CSR_DATA_W-1:0]  csr_data;
   int                              fail_count, pending, checked;
   int                              sample_count, setting_count, cycle_count;
   logic [31:0]                     clock_ms;

   motion_driven_blade_shading dut (.*);

   motion_driven_blade_shading_checker checker_i (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #8_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // result side: random pop with a long hold-off and a no-idle stretch
   always @(posedge clock) begin
      if (reset) begin
         pop         <= 1'b0;
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count >= 3000 && cycle_count < 3400) pop <= 1'b0;
         else if (cycle_count >= 9000 && cycle_count < 13000) pop <= 1'b1;
         else pop <= ($urandom_range(99) >= 26);
      end
   end

   // one register write, valid stays high for the caller to lower
   task automatic csr_put(input mbs_pkg::csr_index_type idx, input int value);
      valid     <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[mbs_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      while (!ready) @(posedge clock);
   endtask

   task automatic set_regs(input int hue, input int freq, input int depth,
                           input int bleed, input int flicker);
      csr_put(mbs_pkg::CSR_BASE_HUE, hue);
      csr_put(mbs_pkg::CSR_IDLE_FREQ, freq);
      csr_put(mbs_pkg::CSR_PULSE_DEPTH, depth);
      csr_put(mbs_pkg::CSR_BLEED_MAX, bleed);
      csr_put(mbs_pkg::CSR_FLICKER, flicker);
      valid <= 1'b0;
      setting_count++;
   endtask

   // wait for every expected result, then let the back end settle
   task automatic drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // one sample transaction, push stays high for the next one
   task automatic send(input mbs_pkg::req_type s, input bit may_idle);
      if (may_idle && $urandom_range(99) < 26) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= s;
      @(posedge clock);
      while (full) @(posedge clock);
      sample_count++;
   endtask

   task automatic send_fields(input int ke, input int tl, input int ov, input bit b,
                              input logic [31:0] t, input logic [31:0] rw);
      mbs_pkg::req_type s;
      s.kinetic_energy = 16'(ke);
      s.tilt           = 16'(tl);
      s.overload       = 12'(ov);
      s.burst          = b;
      s.time_ms        = t;
      s.random_word    = rw;
      send(s, 1'b0);
   endtask

   // random sample: mostly steady time with idle or excited motion
   function automatic mbs_pkg::req_type random_sample();
      mbs_pkg::req_type s;
      int               kind;
      kind = $urandom_range(99);
      s.random_word = $urandom();
      s.burst       = 1'($urandom_range(1));
      s.tilt        = ($urandom_range(3) == 0) ? 16'($urandom())
                                               : 16'($urandom_range(32768) - 16384);
      if ($urandom_range(1)) begin
         s.kinetic_energy = 16'($urandom_range(127));
         s.overload       = 12'd0;
      end else begin
         s.kinetic_energy = ($urandom_range(3) == 0) ? 16'($urandom())
                                                     : 16'($urandom_range(2048));
         s.overload       = ($urandom_range(2) == 0) ? 12'd0 : 12'($urandom());
      end
      if (kind < 80) clock_ms = clock_ms + $urandom_range(0, 300);
      else if (kind < 85) clock_ms = 0;
      else if (kind < 90) clock_ms = clock_ms - $urandom_range(1, 5000);
      else if (kind < 95) clock_ms = clock_ms + $urandom_range(60000, 200000);
      else clock_ms = $urandom();
      s.time_ms = clock_ms;
      return s;
   endfunction

   // stimulus
   initial begin
      push          = 1'b0;
      valid         = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      req_data      = '0;
      reset         = 1'b1;
      sample_count  = 0;
      setting_count = 0;
      clock_ms      = 32'd1000;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset registers, unset time, extremes of every field
      send_fields(0, 0, 0, 0, 0, 0);
      send_fields(100, 16384, 0, 1, 32'd5, 32'hFFFF_FFFF);
      send_fields(127, -16384, 0, 0, 32'd250, 32'h8000_0000);
      send_fields(128, 32767, 0, 1, 32'd400, 32'h7FFF_FFFF);
      send_fields(65535, -32768, 4095, 0, 32'd401, 32'h0);
      send_fields(0, 1, 1, 1, 32'd300, 32'h1234_5678);
      send_fields(1024, 8192, 2048, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fields(1025, -8192, 0, 1, 32'd0, 32'h0000_0001);
      send_fields(50, 100, 0, 0, 32'd70000, 32'hAAAA_AAAA);
      send_fields(0, -1, 0, 1, 32'd135536, 32'h5555_5555);
      push <= 1'b0;
      drain();

      // directed: register extremes, hue wrap and depths beyond full
      set_regs(511, 0, 511, 511, 511);
      send_fields(0, -16384, 0, 1, 32'd10, 32'h0);
      send_fields(65535, 0, 4095, 0, 32'd20, 32'h0);
      send_fields(10, 16384, 0, 1, 32'd1020, 32'hFFFF_FFFF);
      send_fields(300, 0, 2, 0, 32'd1030, 32'h8000_0000);
      push <= 1'b0;
      drain();
      set_regs(359, 4095, 0, 0, 0);
      send_fields(0, 16384, 0, 1, 32'd2000, 32'h0);
      send_fields(0, 0, 0, 0, 32'd2500, 32'h0);
      send_fields(2000, 0, 4095, 1, 32'd2600, 32'h0);
      send_fields(0, 4096, 0, 0, 32'd3000, 32'h0);
      push <= 1'b0;
      drain();
      set_regs(360, 128, 256, 256, 256);
      send_fields(64, -4096, 0, 1, 32'd3500, 32'h0);
      send_fields(600, 0, 4095, 0, 32'd3600, 32'hFFFF_FFFF);
      push <= 1'b0;
      drain();

      // random phases, each under a different register setting
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_regs(0, 256, 64, 128, 256);
            1: set_regs(359, 4095, 256, 0, 0);
            2: set_regs(180, 128, 0, 256, 256);
            3: set_regs(511, 0, 511, 511, 511);
            default: set_regs($urandom_range(511), $urandom_range(4095),
                              $urandom_range(511), $urandom_range(511),
                              $urandom_range(511));
         endcase
         for (int n = 0; n < 110; n++) begin
            send(random_sample(), !(ph == 4 || ph == 5));
            if (ph == 2 && n == 50) begin
               // sender pause until the block is empty
               push <= 1'b0;
               drain();
            end
         end
         push <= 1'b0;
         drain();
      end

      $display("%0d samples over %0d register settings, %0d results compared",
               sample_count, setting_count, checked);
      $display("covered idle pulse, excited flicker, time wrap and bursts");
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
